### rtl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// shared types and constants for the length-prefixed frame parser
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam logic [2:0]  HEADER_BYTES      = 3'd6;
    localparam logic [2:0]  LENGTH_BYTES      = 3'd4;
    localparam logic [15:0] LIGHT_UPDATE_TYPE = 16'd100;
    localparam logic [16:0] UPDATE_FIXED_LEN  = 17'd7;

    typedef struct packed {
        logic [15:0] frame_type;
        logic [31:0] frame_length;
        logic        is_update;
        logic [15:0] id_length;
        logic [7:0]  light_state;
        logic [31:0] countdown;
        logic [63:0] upd_count;
        logic        bad_length;
    } t_result;

endpackage

### rtl/lfp_core.sv
// ----------------------------------------------------------------------------
// lfp_core
// per-word parse state and frame result decode
// ----------------------------------------------------------------------------
module lfp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_emit,
    output lfp_pkg::t_result o_result
);
    import lfp_pkg::*;

    logic [2:0]  r_header_index, n_header_index;
    logic [31:0] r_length,       n_length;
    logic [15:0] r_type,         n_type;
    logic [31:0] r_body_pos,     n_body_pos;
    logic [15:0] r_ident_len,    n_ident_len;
    logic [7:0]  r_state_byte,   n_state_byte;
    logic [31:0] r_countdown,    n_countdown;
    logic [63:0] r_updates,      n_updates;
    logic        r_halted,       n_halted;

    logic        frame_end;
    logic        bad_emit;
    logic        upd;
    logic [31:0] body_size;
    logic [31:0] state_pos;
    logic [16:0] need_len;

    always_comb begin
        n_header_index = r_header_index;
        n_length       = r_length;
        n_type         = r_type;
        n_body_pos     = r_body_pos;
        n_ident_len    = r_ident_len;
        n_state_byte   = r_state_byte;
        n_countdown    = r_countdown;
        n_updates      = r_updates;
        n_halted       = r_halted;
        frame_end      = 1'b0;
        bad_emit       = 1'b0;
        upd            = 1'b0;
        state_pos      = 32'd2 + {16'd0, r_ident_len};
        body_size      = 32'd0;
        need_len       = 17'd0;

        if (i_accept && !r_halted) begin
            if (r_header_index < HEADER_BYTES) begin
                if (r_header_index < LENGTH_BYTES) begin
                    n_length = {r_length[23:0], i_rx_byte};
                end else begin
                    n_type = {r_type[7:0], i_rx_byte};
                end
                n_header_index = r_header_index + 3'd1;
                if (n_header_index == HEADER_BYTES) begin
                    n_body_pos   = 32'd0;
                    n_ident_len  = 16'd0;
                    n_state_byte = 8'd0;
                    n_countdown  = 32'd0;
                    if (n_length < {29'd0, HEADER_BYTES}) begin
                        n_halted = 1'b1;
                        bad_emit = 1'b1;
                    end else if (n_length == {29'd0, HEADER_BYTES}) begin
                        frame_end = 1'b1;
                    end
                end
            end else begin
                if (r_body_pos < 32'd2) begin
                    n_ident_len = {r_ident_len[7:0], i_rx_byte};
                end else if (r_body_pos == state_pos) begin
                    n_state_byte = i_rx_byte;
                end else if (r_body_pos > state_pos && r_body_pos <= state_pos + 32'd4) begin
                    n_countdown = {r_countdown[23:0], i_rx_byte};
                end
                n_body_pos = r_body_pos + 32'd1;
                if (n_body_pos == r_length - {29'd0, HEADER_BYTES}) begin
                    frame_end = 1'b1;
                end
            end
        end

        if (frame_end) begin
            body_size = n_length - {29'd0, HEADER_BYTES};
            need_len  = {1'b0, n_ident_len} + UPDATE_FIXED_LEN;
            upd = (n_type == LIGHT_UPDATE_TYPE) && (body_size >= 32'd2)
                  && ({15'd0, need_len} <= body_size);
            if (upd) begin
                n_updates = r_updates + 64'd1;
            end
            n_header_index = 3'd0;
            n_body_pos     = 32'd0;
        end
    end

    assign o_emit                = frame_end || bad_emit;
    assign o_result.frame_type   = n_type;
    assign o_result.frame_length = n_length;
    assign o_result.is_update    = upd;
    assign o_result.id_length    = upd ? n_ident_len : 16'd0;
    assign o_result.light_state  = upd ? n_state_byte : 8'd0;
    assign o_result.countdown    = upd ? n_countdown : 32'd0;
    assign o_result.upd_count    = n_updates;
    assign o_result.bad_length   = bad_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_index <= 3'd0;
            r_length       <= 32'd0;
            r_type         <= 16'd0;
            r_body_pos     <= 32'd0;
            r_ident_len    <= 16'd0;
            r_state_byte   <= 8'd0;
            r_countdown    <= 32'd0;
            r_updates      <= 64'd0;
            r_halted       <= 1'b0;
        end else begin
            r_header_index <= n_header_index;
            r_length       <= n_length;
            r_type         <= n_type;
            r_body_pos     <= n_body_pos;
            r_ident_len    <= n_ident_len;
            r_state_byte   <= n_state_byte;
            r_countdown    <= n_countdown;
            r_updates      <= n_updates;
            r_halted       <= n_halted;
        end
    end

endmodule

### rtl/length_prefixed_frame_parser_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_top
// byte-stream deframer for length-prefixed messages with light update decode
// a frame result is valid in the cycle after its last word is accepted
// throughput: one word per cycle if o_ready, set by the single result register
// a word is taken while a result waits as long as that result is taken too
// reset: synchronous active low, clears parse state, counter and halt flag
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_frame_type,
    output logic [31:0] o_frame_length,
    output logic        o_is_update,
    output logic [15:0] o_id_length,
    output logic [7:0]  o_light_state,
    output logic [31:0] o_countdown,
    output logic [63:0] o_upd_count,
    output logic        o_bad_length
);
    import lfp_pkg::*;

    logic    accept;
    logic    emit;
    t_result result;
    t_result r_out;
    logic    r_out_valid;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    lfp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_emit    (emit),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_type   = r_out.frame_type;
    assign o_frame_length = r_out.frame_length;
    assign o_is_update    = r_out.is_update;
    assign o_id_length    = r_out.id_length;
    assign o_light_state  = r_out.light_state;
    assign o_countdown    = r_out.countdown;
    assign o_upd_count    = r_out.upd_count;
    assign o_bad_length   = r_out.bad_length;

endmodule
